// ===== hw/rtl/mlfq_pkg.sv =====
`default_nettype none
package mlfq_pkg;
  localparam int MAX_LEVELS_DEF  = 8;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int ID_W    = 16;
  localparam int BURST_W = 16;
  localparam int LVL_IN_W = 4;
  localparam int RUN_LVL_W = 3;
  localparam int ENTRY_W = ID_W + BURST_W;

  localparam logic [3:0]  LEVEL_COUNT_RST  = 4'd8;
  localparam logic [15:0] SLICE_LENGTH_RST = 16'd1;

  localparam logic CFG_LEVEL_COUNT  = 1'b0;
  localparam logic CFG_SLICE_LENGTH = 1'b1;

  localparam logic OP_ENQUEUE  = 1'b0;
  localparam logic OP_DISPATCH = 1'b1;

  typedef enum logic [2:0] {
    ST_QUEUED     = 3'd0,
    ST_BAD_LEVEL  = 3'd1,
    ST_FULL       = 3'd2,
    ST_DISPATCHED = 3'd3,
    ST_IDLE       = 3'd4
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;   // latch request, start RAM read of head
    logic finish;    // compute result, do writes
    logic out_load;  // load output register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_enqueue;
  } dp_stat_t;
endpackage
`default_nettype wire

// ===== hw/rtl/mlfq_if.sv =====
`default_nettype none
interface mlfq_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [15:0] job_id;
  logic [15:0] burst;
  logic [3:0]  level;
  modport source (output valid, op, job_id, burst, level, input ready);
  modport sink   (input valid, op, job_id, burst, level, output ready);
endinterface

interface mlfq_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] run_id;
  logic [2:0]  run_level;
  logic [15:0] run_time;
  logic        finished;
  modport source (output valid, status, run_id, run_level, run_time, finished, input ready);
  modport sink   (input valid, status, run_id, run_level, run_time, finished, output ready);
endinterface

interface mlfq_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/mlfq_ram.sv =====
`default_nettype none
module mlfq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hw/rtl/mlfq_ctrl.sv =====
`default_nettype none
module mlfq_ctrl import mlfq_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);
  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_HOLD} state_t;
  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // output register free, or drained this cycle
  logic out_free;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    in_ready      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC, S_HOLD: begin
        if (out_free) begin
          cmd.finish    = 1'b1;
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_HOLD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  logic unused_stat;
  assign unused_stat = stat.is_enqueue;
endmodule
`default_nettype wire

// ===== hw/rtl/mlfq_dp.sv =====
`default_nettype none
module mlfq_dp import mlfq_pkg::*; #(
  parameter int MAX_LEVELS  = MAX_LEVELS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire dp_cmd_t       cmd,
  output dp_stat_t           stat,
  input  wire logic          in_op,
  input  wire logic [15:0]   in_job_id,
  input  wire logic [15:0]   in_burst,
  input  wire logic [3:0]    in_level,
  input  wire logic          cfg_we,
  input  wire logic          cfg_index,
  input  wire logic [15:0]   cfg_data,
  output logic [2:0]         out_status,
  output logic [15:0]        out_run_id,
  output logic [2:0]         out_run_level,
  output logic [15:0]        out_run_time,
  output logic               out_finished
);
  localparam int LW  = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int PW  = $clog2(QUEUE_DEPTH);
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int DEPTH = MAX_LEVELS * QUEUE_DEPTH;
  localparam int AW  = $clog2(DEPTH);
  localparam logic [CW-1:0] QD = CW'(QUEUE_DEPTH);

  logic [3:0]  level_count_r;
  logic [15:0] slice_r;
  logic [PW-1:0] head_r [MAX_LEVELS];
  logic [PW-1:0] tail_r [MAX_LEVELS];
  logic [CW-1:0] cnt_r  [MAX_LEVELS];

  logic        op_r;
  logic [15:0] id_r, burst_r;
  logic [3:0]  lvl_r;
  logic        found_r;
  logic [LW-1:0] cur_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_count_r <= LEVEL_COUNT_RST;
      slice_r       <= SLICE_LENGTH_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_LEVEL_COUNT) level_count_r <= cfg_data[3:0];
      else slice_r <= cfg_data;
    end
  end

  // levels in use, clamped
  logic [4:0] used;
  assign used = ({1'b0, level_count_r} > 5'(MAX_LEVELS)) ? 5'(MAX_LEVELS)
                                                        : {1'b0, level_count_r};

  // highest non-empty level below used (independent compares, priority pick)
  logic          found_c;
  logic [LW-1:0] cur_c;
  always_comb begin
    found_c = 1'b0;
    cur_c   = '0;
    for (int k = 0; k < MAX_LEVELS; k++) begin
      if (5'(k) < used && cnt_r[k] != '0) begin
        found_c = 1'b1;
        cur_c   = LW'(k);
      end
    end
  end

  function automatic logic [AW-1:0] addr(input logic [LW-1:0] l, input logic [PW-1:0] s);
    addr = AW'((int'(l) * QUEUE_DEPTH) + int'(s));
  endfunction

  logic [AW-1:0]      raddr;
  logic [ENTRY_W-1:0] rdata;
  logic               we;
  logic [AW-1:0]      waddr;
  logic [ENTRY_W-1:0] wdata;

  assign raddr = addr(cur_c, head_r[cur_c]);

  mlfq_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= in_op;
      id_r    <= in_job_id;
      burst_r <= in_burst;
      lvl_r   <= in_level;
      found_r <= found_c;
      cur_r   <= cur_c;
    end
  end

  // result computation
  logic          enq_ok, enq_bad, enq_full;
  logic [LW-1:0] enq_lvl;
  logic [15:0]   jb, rt, left;
  logic          dem_full, push_back;
  logic [LW-1:0] dest;
  logic          do_pop;
  status_t       st;

  assign enq_lvl  = lvl_r[LW-1:0];
  assign enq_bad  = {1'b0, lvl_r} >= used;
  assign enq_full = !enq_bad && (cnt_r[enq_lvl] >= QD);
  assign enq_ok   = !enq_bad && !enq_full;
  assign jb       = rdata[BURST_W-1:0];
  assign rt       = (cur_r == '0) ? jb : ((jb < slice_r) ? jb : slice_r);
  assign left     = jb - rt;
  assign dem_full = (cur_r != '0) && (cnt_r[cur_r - LW'(1)] >= QD);
  assign dest     = dem_full ? cur_r : cur_r - LW'(1);
  assign do_pop   = cmd.finish && op_r == OP_DISPATCH && found_r;
  assign push_back = do_pop && cur_r != '0 && left != '0;

  always_comb begin
    we    = 1'b0;
    waddr = addr(enq_lvl, tail_r[enq_lvl]);
    wdata = {id_r, burst_r};
    if (cmd.finish && op_r == OP_ENQUEUE && enq_ok) begin
      we = 1'b1;
    end else if (push_back) begin
      we    = 1'b1;
      waddr = addr(dest, tail_r[dest]);
      wdata = {rdata[ENTRY_W-1:BURST_W], left};
    end
  end

  always_comb begin
    priority if (op_r == OP_ENQUEUE) begin
      st = enq_bad ? ST_BAD_LEVEL : (enq_full ? ST_FULL : ST_QUEUED);
    end else if (!found_r) begin
      st = ST_IDLE;
    end else begin
      st = ST_DISPATCHED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_LEVELS; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else if (cmd.finish) begin
      for (int i = 0; i < MAX_LEVELS; i++) begin
        logic inc, dec;
        inc = (op_r == OP_ENQUEUE && enq_ok && enq_lvl == LW'(i)) ||
              (push_back && dest == LW'(i));
        dec = do_pop && cur_r == LW'(i);
        if (inc) tail_r[i] <= (tail_r[i] == PW'(QUEUE_DEPTH - 1)) ? '0 : tail_r[i] + PW'(1);
        if (dec) head_r[i] <= (head_r[i] == PW'(QUEUE_DEPTH - 1)) ? '0 : head_r[i] + PW'(1);
        if (inc && !dec) cnt_r[i] <= cnt_r[i] + CW'(1);
        else if (dec && !inc) cnt_r[i] <= cnt_r[i] - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status    <= st;
      out_run_id    <= (st == ST_DISPATCHED) ? rdata[ENTRY_W-1:BURST_W] : '0;
      out_run_level <= (st == ST_DISPATCHED) ? RUN_LVL_W'(cur_r) : '0;
      out_run_time  <= (st == ST_DISPATCHED) ? rt : '0;
      out_finished  <= (st == ST_DISPATCHED) && (cur_r == '0 || left == '0);
    end
  end

  assign stat.is_enqueue = (op_r == OP_ENQUEUE);
endmodule
`default_nettype wire

// ===== hw/rtl/multilevel_feedback_queue_scheduler_unit.sv =====
`default_nettype none
// Channel  Dir  Payload                                         Accepted when
// in_      in   op, job_id, burst, level                        in_valid & in_ready
// out_     out  status, run_id, run_level, run_time, finished   out_valid & out_ready
// cfg_     in   index (0 level_count, 1 slice_length), data     cfg_valid & cfg_ready
//
// Each request is handled as a registered job-store read of the head of the
// chosen level, then a compute and write-back step (enqueue or demote).
// Output register lets a request be taken while the previous result waits;
// a stalled output holds the compute step. Reset (rst_n, sync) empties all
// queues; the job store itself needs no clearing.
module multilevel_feedback_queue_scheduler_unit import mlfq_pkg::*; #(
  parameter int MAX_LEVELS  = MAX_LEVELS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  mlfq_in_if.sink    in_ch,
  mlfq_out_if.source out_ch,
  mlfq_cfg_if.sink   cfg_ch
);
  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ch.ready = 1'b1;

  mlfq_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .stat, .cmd
  );

  mlfq_dp #(.MAX_LEVELS(MAX_LEVELS), .QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
    .clk, .rst_n, .cmd, .stat,
    .in_op(in_ch.op), .in_job_id(in_ch.job_id), .in_burst(in_ch.burst),
    .in_level(in_ch.level),
    .cfg_we(cfg_ch.valid), .cfg_index(cfg_ch.index), .cfg_data(cfg_ch.data),
    .out_status(out_ch.status), .out_run_id(out_ch.run_id),
    .out_run_level(out_ch.run_level), .out_run_time(out_ch.run_time),
    .out_finished(out_ch.finished)
  );

`ifndef SYNTHESIS
  // no request is taken in the cycle right after one is accepted
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready) else $error("back-to-back accept");
  // results other than dispatched carry zero run fields
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status != ST_DISPATCHED) |->
      (out_ch.run_id == '0 && out_ch.run_time == '0 && !out_ch.finished))
    else $error("nonzero run fields");
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.status <= ST_IDLE) else $error("bad status");
`endif
endmodule
`default_nettype wire

// ===== bench/multilevel_feedback_queue_scheduler_unit_tb.sv =====
`timescale 1ns / 1ps
import mlfq_pkg::*;

typedef struct packed {
  logic [2:0]  status;
  logic [15:0] run_id;
  logic [2:0]  run_level;
  logic [15:0] run_time;
  logic        finished;
} answer_t;

// Scheduler scoreboard: mirrors the per-level job queues and holds the
// answers still owed by the block.
class sched_board;
  logic [31:0] jobs[8][$];
  logic [3:0]  level_count;
  logic [15:0] slice_length;
  answer_t     owed[$];
  int          errors;
  int          answers;
  int          dispatches;
  int          demotions;
  int          full_hits;

  function new();
    level_count  = LEVEL_COUNT_RST;
    slice_length = SLICE_LENGTH_RST;
    errors = 0;
    answers = 0;
    dispatches = 0;
    demotions = 0;
    full_hits = 0;
  endfunction

  function int depth_of(int lv);
    return jobs[lv].size();
  endfunction

  function int used_levels();
    return (level_count > MAX_LEVELS_DEF) ? MAX_LEVELS_DEF : int'(level_count);
  endfunction

  // Works out the answer for one accepted request and updates the queues.
  function void note_request(logic op, logic [15:0] id, logic [15:0] burst,
                             logic [3:0] lv);
    answer_t a;
    int used;
    int cur;
    int dest;
    logic [31:0] e;
    logic [15:0] left;
    a = '0;
    used = used_levels();
    if (op == OP_ENQUEUE) begin
      if (int'(lv) >= used) a.status = ST_BAD_LEVEL;
      else if (jobs[lv].size() >= QUEUE_DEPTH_DEF) begin
        a.status = ST_FULL;
        full_hits++;
      end else begin
        jobs[lv].push_back({id, burst});
        a.status = ST_QUEUED;
      end
    end else begin
      cur = -1;
      for (int k = used - 1; k >= 0; k--)
        if (cur < 0 && jobs[k].size() != 0) cur = k;
      if (cur < 0) a.status = ST_IDLE;
      else begin
        e = jobs[cur].pop_front();
        dispatches++;
        a.status = ST_DISPATCHED;
        a.run_id = e[31:16];
        a.run_level = cur[2:0];
        if (cur == 0) begin
          a.run_time = e[15:0];
          a.finished = 1'b1;
        end else begin
          a.run_time = (e[15:0] < slice_length) ? e[15:0] : slice_length;
          left = e[15:0] - a.run_time;
          if (left == 0) a.finished = 1'b1;
          else begin
            // demote one level; a full target sends it back to its own tail
            dest = (jobs[cur - 1].size() >= QUEUE_DEPTH_DEF) ? cur : cur - 1;
            jobs[dest].push_back({e[31:16], left});
            demotions++;
          end
        end
      end
    end
    owed.push_back(a);
  endfunction

  function answer_t take_oldest(output bit none);
    none = (owed.size() == 0);
    if (none) return '0;
    return owed.pop_front();
  endfunction
endclass

module multilevel_feedback_queue_scheduler_unit_tb;
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #5 clk = ~clk;

  mlfq_in_if  in_ch();
  mlfq_out_if out_ch();
  mlfq_cfg_if cfg_ch();

  multilevel_feedback_queue_scheduler_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  sched_board board;
  int send_idle_pct;
  int recv_idle_pct;
  int quiet_cycles;
  int requests_sent;
  bit timed_out;

  localparam int WATCHDOG_LIMIT = 20000;

  // Mismatch report: one line per failing field, counted on the board.
  task automatic report(string what, int got, int want);
    board.errors++;
    $display("ERROR t=%0t %s: got %0d expected %0d", $time, what, got, want);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.op = OP_ENQUEUE;
    in_ch.job_id = '0;
    in_ch.burst = '0;
    in_ch.level = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_LEVEL_COUNT;
    cfg_ch.data = '0;
  end

  // Result side: random stall per cycle, check every accepted result.
  always @(posedge clk) begin
    answer_t want;
    bit none;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        want = board.take_oldest(none);
        board.answers++;
        if (none) report("result with no request pending", out_ch.status, -1);
        else begin
          if (out_ch.status !== want.status) report("status", out_ch.status, want.status);
          if (out_ch.run_id !== want.run_id) report("run_id", out_ch.run_id, want.run_id);
          if (out_ch.run_level !== want.run_level)
            report("run_level", out_ch.run_level, want.run_level);
          if (out_ch.run_time !== want.run_time)
            report("run_time", out_ch.run_time, want.run_time);
          if (out_ch.finished !== want.finished)
            report("finished", out_ch.finished, want.finished);
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: cycles with no request, result or register write accepted.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      timed_out = 1'b1;
      $display("Watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  // One request; the sender may idle a random number of cycles first.
  // Valid stays up after the accept so back-to-back requests need no gap;
  // drain() or an idle cycle drops it.
  task automatic send_request(logic op, logic [15:0] id, logic [15:0] burst,
                              logic [3:0] lv);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.op     <= op;
    in_ch.job_id <= id;
    in_ch.burst  <= burst;
    in_ch.level  <= lv;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.note_request(op, id, burst, lv);
    requests_sent++;
  endtask

  // Drop valid and let every owed result drain, then idle for a margin.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (board.owed.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] value);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    if (idx == CFG_LEVEL_COUNT) board.level_count = value[3:0];
    else board.slice_length = value;
  endtask

  // Random request mix; enqueues lean toward levels in use and short bursts
  // so jobs get demoted through the levels and sometimes fill a queue.
  task automatic random_request(int enq_pct);
    logic [15:0] burst;
    logic [3:0]  lv;
    int used;
    used = board.used_levels();
    case ($urandom_range(9))
      0:       burst = 16'($urandom_range(65535));
      1:       burst = 16'd0;
      2:       burst = 16'hffff;
      default: burst = 16'($urandom_range(12));
    endcase
    if (used == 0 || $urandom_range(9) == 0) lv = 4'($urandom_range(15));
    else lv = 4'($urandom_range(used - 1));
    if ($urandom_range(99) < enq_pct)
      send_request(OP_ENQUEUE, 16'($urandom_range(65535)), burst, lv);
    else
      send_request(OP_DISPATCH, 16'($urandom_range(65535)),
                   16'($urandom_range(65535)), 4'($urandom_range(15)));
  endtask

  initial begin
    board = new();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    quiet_cycles = 0;
    requests_sent = 0;
    timed_out = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: dispatch when empty, all field extremes, bad levels.
    send_request(OP_DISPATCH, 16'hffff, 16'hffff, 4'hf);
    send_request(OP_ENQUEUE, 16'hffff, 16'hffff, 4'd7);
    send_request(OP_ENQUEUE, 16'h0000, 16'h0000, 4'd7);
    send_request(OP_ENQUEUE, 16'h1234, 16'd3, 4'd0);
    send_request(OP_ENQUEUE, 16'h5555, 16'd5, 4'd8);
    send_request(OP_ENQUEUE, 16'haaaa, 16'd5, 4'hf);
    repeat (6) send_request(OP_DISPATCH, 16'd0, 16'd0, 4'd0);
    // Fill level 7, then overflow it.
    for (int i = 0; i < QUEUE_DEPTH_DEF + 1; i++)
      send_request(OP_ENQUEUE, 16'(i), 16'd2, 4'd7);
    // Level 6 full too: demotions out of 7 must go back to its own tail.
    for (int i = 0; i < QUEUE_DEPTH_DEF; i++)
      send_request(OP_ENQUEUE, 16'(100 + i), 16'd4, 4'd6);
    repeat (4) send_request(OP_DISPATCH, 16'd0, 16'd0, 4'd0);

    // Zero slice: nothing is granted but jobs still move down.
    write_reg(CFG_SLICE_LENGTH, 16'd0);
    repeat (4) send_request(OP_DISPATCH, 16'd0, 16'd0, 4'd0);
    // Shrink to two levels: upper jobs are parked and stay stored.
    write_reg(CFG_LEVEL_COUNT, 16'd2);
    write_reg(CFG_SLICE_LENGTH, 16'hffff);
    repeat (3) send_request(OP_DISPATCH, 16'd0, 16'd0, 4'd0);
    send_request(OP_ENQUEUE, 16'd9, 16'd1, 4'd2);
    // No levels at all; then above the parameter (acts as eight).
    write_reg(CFG_LEVEL_COUNT, 16'd0);
    send_request(OP_ENQUEUE, 16'd7, 16'd1, 4'd0);
    send_request(OP_DISPATCH, 16'd0, 16'd0, 4'd0);
    write_reg(CFG_LEVEL_COUNT, 16'hf);

    // Random phases: receiver idles more, then sender idles more, then neither idles.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase % 3)
        0: begin send_idle_pct = 20; recv_idle_pct = 46; end
        1: begin send_idle_pct = 46; recv_idle_pct = 20; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      case (phase)
        0: begin write_reg(CFG_LEVEL_COUNT, 16'd8); write_reg(CFG_SLICE_LENGTH, 16'd1); end
        1: begin write_reg(CFG_LEVEL_COUNT, 16'd3); write_reg(CFG_SLICE_LENGTH, 16'd3); end
        2: begin write_reg(CFG_LEVEL_COUNT, 16'd1); write_reg(CFG_SLICE_LENGTH, 16'd2); end
        3: begin write_reg(CFG_LEVEL_COUNT, 16'hf); write_reg(CFG_SLICE_LENGTH, 16'd0); end
        4: begin write_reg(CFG_LEVEL_COUNT, 16'd5); write_reg(CFG_SLICE_LENGTH, 16'hffff); end
        default: begin write_reg(CFG_LEVEL_COUNT, 16'd8); write_reg(CFG_SLICE_LENGTH, 16'd4); end
      endcase
      for (int n = 0; n < 315; n++)
        random_request((n % 100 < 50) ? 65 : 40);
    end

    drain();
    repeat (20) @(posedge clk);
    $display("Run covered %0d requests, %0d results, %0d dispatches, %0d demotions,",
             requests_sent, board.answers, board.dispatches, board.demotions);
    $display("%0d full-queue answers, over six register settings and three stall mixes.",
             board.full_hits);
    if (board.errors == 0 && board.owed.size() == 0)
      $display("Verification passed");
    else begin
      $display("%0d mismatches, %0d results missing", board.errors, board.owed.size());
      $display("Verification failed");
    end
    $finish;
  end
endmodule

// ===== files.f =====
hw/rtl/mlfq_pkg.sv
hw/rtl/mlfq_if.sv
hw/rtl/mlfq_ram.sv
hw/rtl/mlfq_ctrl.sv
hw/rtl/mlfq_dp.sv
hw/rtl/multilevel_feedback_queue_scheduler_unit.sv
bench/multilevel_feedback_queue_scheduler_unit_tb.sv
